// ===== hw/rtl/ffp_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit placer package
// Sizes, field widths, map word layout and sequencer states that are shared
// by the placer's interfaces, top level and port checker.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int MACHINES = 8;
  localparam int HORIZON  = 64;

  localparam int JOB_W  = 8;
  localparam int OP_W   = 8;
  localparam int MACH_W = 3;
  localparam int DUR_W  = 7;
  localparam int OUT_W  = 7;

  localparam int DEPTH   = MACHINES * HORIZON;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W  = $clog2(HORIZON + 1);
  localparam int OWNER_W = JOB_W + OP_W;
  localparam int MAP_W   = OWNER_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/ffp_if.sv =====
// ----------------------------------------------------------------------------
// First-fit placer channels
// Valid/ready channels for placement requests and placement results.
// ----------------------------------------------------------------------------
interface ffp_req_if;
  import ffp_pkg::*;

  logic              valid;
  logic              ready;
  logic [JOB_W-1:0]  job_id;
  logic [OP_W-1:0]   op_id;
  logic [MACH_W-1:0] machine;
  logic [DUR_W-1:0]  duration;

  modport source (output valid, job_id, op_id, machine, duration, input ready);
  modport sink   (input valid, job_id, op_id, machine, duration, output ready);
endinterface

interface ffp_rsp_if;
  import ffp_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] start_slot;
  logic [OUT_W-1:0] end_slot;
  logic             no_room;

  modport source (output valid, start_slot, end_slot, no_room, input ready);
  modport sink   (input valid, start_slot, end_slot, no_room, output ready);
endinterface

// ===== hw/rtl/timeline_first_fit_placer_top.sv =====
// ----------------------------------------------------------------------------
// Timeline first-fit placer
// Places operations on a machine-by-time occupancy map, first fit.
// ----------------------------------------------------------------------------
// A request carries a job id, an operation id, a machine and a duration. The
// block scans that machine's row for the first run of free slots that is long
// enough, starting where the last placement ended if it was for the same job,
// or at slot 0 otherwise. It marks the run and returns its start and end
// slots, or sets no_room when nothing fits before the horizon or the machine
// or duration is out of range.
// After reset the block sweeps all MACHINES * HORIZON words (512 here) of the
// map to free, one slot per cycle, and holds req.ready low meanwhile.
// One request is handled at a time. The scan reads one slot per cycle from
// the map memory; each item is accepted, its row is scanned, each slot of the
// run is marked in turn and the result is then posted.
// The result sits in an output register; a new request is taken while it
// waits, but the next result is not posted until the receiver has taken the
// previous one.
// ----------------------------------------------------------------------------
module timeline_first_fit_placer_top (
  input logic      clk,
  input logic      rst,
  ffp_req_if.sink  req,
  ffp_rsp_if.source rsp
);
  import ffp_pkg::*;

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0] clr_addr;
  logic [JOB_W-1:0]  job;
  logic [OP_W-1:0]   op;
  logic [DUR_W-1:0]  dur;
  logic [ADDR_W-1:0] row_base;
  logic              nr;
  logic [SLOT_W-1:0] rd_slot;
  logic              chk_vld;
  logic [SLOT_W-1:0] chk_slot;
  logic [SLOT_W-1:0] run_len;
  logic [SLOT_W-1:0] run_start;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] mark_slot;
  logic [SLOT_W-1:0] mark_left;
  logic [JOB_W-1:0]  last_job;
  logic [OUT_W-1:0]  last_end;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [MAP_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [MAP_W-1:0]  ram_rdata;

  logic              req_bad;
  logic              rd_ok;
  logic              busy_bit;
  logic              hit;
  logic              scan_fail;
  logic [SLOT_W-1:0] hit_start;
  logic [SLOT_W-1:0] hit_end;
  logic              out_free;

  ffp_ram #(
    .WIDTH (MAP_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_bad   = (32'(req.machine) >= MACHINES) || (32'(req.duration) > HORIZON);
  assign rd_ok     = 32'(rd_slot) < HORIZON;
  assign busy_bit  = ram_rdata[MAP_W-1];
  assign hit       = (state == ST_SCAN) && chk_vld && !busy_bit &&
                     ((dur == '0) || ((run_len + SLOT_W'(1)) == SLOT_W'(dur)));
  assign scan_fail = (state == ST_SCAN) && !chk_vld && !rd_ok;
  assign hit_start = (run_len == '0) ? chk_slot : run_start;
  assign hit_end   = hit_slot + SLOT_W'(dur);
  assign out_free  = !rsp.valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_next = req_bad ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = (dur == '0) ? ST_DONE : ST_MARK;
        end else if (scan_fail) begin
          state_next = ST_DONE;
        end
      end
      ST_MARK: begin
        if (mark_left == SLOT_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    ram_we    = (state == ST_CLEAR) || (state == ST_MARK);
    ram_waddr = (state == ST_CLEAR) ? clr_addr : ADDR_W'(row_base + ADDR_W'(mark_slot));
    ram_wdata = (state == ST_CLEAR) ? '0 : {1'b1, job, op};
    ram_raddr = ADDR_W'(row_base + ADDR_W'(rd_slot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      chk_vld   <= 1'b0;
      rsp.valid <= 1'b0;
      last_job  <= '0;
      last_end  <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_DONE) && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (req.valid) begin
            job      <= req.job_id;
            op       <= req.op_id;
            dur      <= req.duration;
            row_base <= ADDR_W'(32'(req.machine) * HORIZON);
            rd_slot  <= (req.job_id == last_job) ? SLOT_W'(last_end) : '0;
            chk_vld  <= 1'b0;
            run_len  <= '0;
            nr       <= req_bad;
          end
        end
        ST_SCAN: begin
          chk_vld  <= rd_ok;
          chk_slot <= rd_slot;
          if (rd_ok) begin
            rd_slot <= rd_slot + SLOT_W'(1);
          end
          if (chk_vld) begin
            if (busy_bit) begin
              run_len <= '0;
            end else begin
              if (run_len == '0) begin
                run_start <= chk_slot;
              end
              run_len <= run_len + SLOT_W'(1);
            end
          end
          if (hit) begin
            hit_slot  <= hit_start;
            mark_slot <= hit_start;
            mark_left <= SLOT_W'(dur);
            nr        <= 1'b0;
          end else if (scan_fail) begin
            nr <= 1'b1;
          end
        end
        ST_MARK: begin
          mark_slot <= mark_slot + SLOT_W'(1);
          mark_left <= mark_left - SLOT_W'(1);
        end
        ST_DONE: begin
          if (out_free) begin
            rsp.no_room    <= nr;
            rsp.start_slot <= nr ? '0 : OUT_W'(hit_slot);
            rsp.end_slot   <= nr ? '0 : OUT_W'(hit_end);
            if (!nr) begin
              last_job <= job;
              last_end <= OUT_W'(hit_end);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ffp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ffp_chk.sv =====
// ----------------------------------------------------------------------------
// First-fit placer port checker
// Watches the placer's request and result channels over time.
// ----------------------------------------------------------------------------
module ffp_chk (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [ffp_pkg::OUT_W-1:0] start_slot,
  input logic [ffp_pkg::OUT_W-1:0] end_slot,
  input logic                     no_room
);
  import ffp_pkg::*;

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("Request taken while the map is still being cleared.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("Second request taken while one is in flight.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(start_slot) &&
                                   $stable(end_slot) && $stable(no_room)))
    else $error("Stalled result changed or dropped.");

  a_no_room_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && no_room) |-> (start_slot == '0 && end_slot == '0))
    else $error("Failed placement reports nonzero slots.");

endmodule

bind timeline_first_fit_placer_top ffp_chk u_ffp_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .start_slot (rsp.start_slot),
  .end_slot   (rsp.end_slot),
  .no_room    (rsp.no_room)
);
